// ===== src/tbt_pkg.sv =====
// Package for the TOML byte tokenizer: types, codes and constants.
package tbt_pkg;

  localparam int unsigned MaxRun = 32;
  localparam int unsigned RunAw = $clog2(MaxRun);
  localparam int unsigned CntW = RunAw + 1;
  localparam int unsigned MaxResults = 40;

  typedef enum logic [3:0] {
    TokEq     = 4'd0,
    TokLBrk   = 4'd1,
    TokRBrk   = 4'd2,
    TokLBrc   = 4'd3,
    TokRBrc   = 4'd4,
    TokComma  = 4'd5,
    TokDot    = 4'd6,
    TokString = 4'd7,
    TokBool   = 4'd8,
    TokIdent  = 4'd9,
    TokInt    = 4'd10,
    TokFloat  = 4'd11,
    TokDate   = 4'd12,
    TokUnrec  = 4'd13,
    TokEof    = 4'd14
  } tok_e;

  typedef enum logic [2:0] {
    ErrNone  = 3'd0,
    ErrLineBreak = 3'd1,
    ErrUnterm = 3'd2,
    ErrUntermMl = 3'd3,
    ErrRunLong = 3'd4
  } err_e;

  typedef enum logic [3:0] {
    MIdle, MComment, MIdent, MNumber, MQ1, MQ2, MBody, MEsc, MMl
  } mode_e;

  // Sequencer of the top level.
  typedef enum logic [2:0] {
    SAccept,   // waiting for a request
    SEmit,     // held byte being lexed once the output slot is free
    SFlushRd,  // run buffer read issued
    SFlushScan,// scanning run bytes
    SFinish    // end-of-document results
  } seq_e;

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_run(logic [7:0] c);
    return is_digit(c) || c == 8'h2d || c == 8'h3a || c == 8'h2e || c == 8'h54 ||
           c == 8'h5a;
  endfunction

  // True when a byte lexed from idle gives a token of its own.
  function automatic logic idle_has_token(logic [7:0] c);
    return !(c == 8'h20 || c == 8'h0d || c == 8'h09 || c == 8'h0a || c == 8'h23 ||
             c == 8'h22 || c == 8'h27 || is_alpha(c) || c == 8'h5f || is_digit(c) ||
             c == 8'h2d || c == 8'h2b);
  endfunction

  function automatic logic [7:0] true_chr(logic [2:0] k);
    case (k)
      3'd0: return 8'h74;
      3'd1: return 8'h72;
      3'd2: return 8'h75;
      3'd3: return 8'h65;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] false_chr(logic [2:0] k);
    case (k)
      3'd0: return 8'h66;
      3'd1: return 8'h61;
      3'd2: return 8'h6c;
      3'd3: return 8'h73;
      3'd4: return 8'h65;
      default: return 8'h00;
    endcase
  endfunction

endpackage

// ===== src/tbt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tbt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/toml_byte_tokenizer_unit.sv =====
// TOML byte tokenizer: lexes a byte stream into tokens, with a run buffer in RAM.
// A byte is registered at acceptance, lexed in SEmit, and any token it completes is registered
// in the output slot; a new byte is accepted only in SAccept, once the last byte is lexed and
// the output slot is free. A number run is scanned from the run RAM byte by byte (read in
// SFlushRd, then scan in SFlushScan), and each waiting result can stall the sequencer.
// Reset: all lexer state returns to idle, line one, offset zero; run RAM is not cleared.
module toml_byte_tokenizer_unit
  import tbt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  byte_req_i,
  input  logic        final_byte_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [3:0]  token_type_o,
  output logic [31:0] start_offset_o,
  output logic [31:0] token_length_o,
  output logic [15:0] line_number_o,
  output logic [15:0] column_o,
  output logic [2:0]  error_code_o,
  output logic        last_result_o
);

  // Architectural state.
  mode_e       mode_q, mode_d;
  logic        lit_q, lit_d;
  logic [15:0] line_q, line_d;
  logic [31:0] lso_q, lso_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] tstart_q, tstart_d;
  logic [1:0]  hyph_q, hyph_d;
  logic [1:0]  cols_q, cols_d;
  logic        date_q, date_d;
  logic        rtrue_q, rtrue_d;
  logic        rfalse_q, rfalse_d;
  logic        err_q, err_d;
  logic [1:0]  look_q, look_d;

  // Sequencer state.
  seq_e        seq_q, seq_d;
  logic [7:0]  byte_q, byte_d;
  logic        fin_q, fin_d;
  logic [CntW-1:0] idx_q, idx_d;   // scan position
  logic [CntW-1:0] n_q, n_d;       // run length, clamped
  logic [CntW-1:0] tokb_q, tokb_d; // start of the number token being scanned
  logic [1:0]  nph_q, nph_d;       // number scan phase: 0 start, 1 int, 2 dot seen, 3 frac
  logic        frem_q, frem_d;     // redo the held byte after a flush

  // Output slot.
  logic        ov_q, ov_d;
  logic [3:0]  otype_q, otype_d;
  logic [31:0] ostart_q, ostart_d;
  logic [31:0] olen_q, olen_d;
  logic [15:0] oline_q, oline_d;
  logic [15:0] ocol_q, ocol_d;
  logic [2:0]  oerr_q, oerr_d;
  logic        olast_q, olast_d;
  logic [5:0]  ocnt_q, ocnt_d;

  // Run RAM.
  logic             ram_we;
  logic [RunAw-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  tbt_ram #(.Width(8), .Depth(MaxRun)) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MIdle; lit_q <= 1'b0; line_q <= 16'd1; lso_q <= '0; pos_q <= '0;
      tstart_q <= '0; hyph_q <= '0; cols_q <= '0; date_q <= 1'b0; rtrue_q <= 1'b0;
      rfalse_q <= 1'b0; err_q <= 1'b0; look_q <= '0; seq_q <= SAccept; ov_q <= 1'b0;
      ocnt_q <= '0; fin_q <= 1'b0; frem_q <= 1'b0; idx_q <= '0; n_q <= '0;
      tokb_q <= '0; nph_q <= '0;
    end else begin
      mode_q <= mode_d; lit_q <= lit_d; line_q <= line_d; lso_q <= lso_d; pos_q <= pos_d;
      tstart_q <= tstart_d; hyph_q <= hyph_d; cols_q <= cols_d; date_q <= date_d;
      rtrue_q <= rtrue_d; rfalse_q <= rfalse_d; err_q <= err_d; look_q <= look_d;
      seq_q <= seq_d; ov_q <= ov_d; ocnt_q <= ocnt_d; fin_q <= fin_d; frem_q <= frem_d;
      idx_q <= idx_d; n_q <= n_d; tokb_q <= tokb_d; nph_q <= nph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    otype_q <= otype_d; ostart_q <= ostart_d; olen_q <= olen_d; oline_q <= oline_d;
    ocol_q <= ocol_d; oerr_q <= oerr_d; olast_q <= olast_d;
  end

  logic        slot_free;
  logic        acc;
  assign slot_free = !ov_q || ready_i;
  assign ready_o   = (seq_q == SAccept) && slot_free;
  assign acc       = valid_i && ready_o;

  assign valid_o        = ov_q;
  assign token_type_o   = otype_q;
  assign start_offset_o = ostart_q;
  assign token_length_o = olen_q;
  assign line_number_o  = oline_q;
  assign column_o       = ocol_q;
  assign error_code_o   = oerr_q;
  assign last_result_o  = olast_q;

  // Result request built by the lexer this cycle.
  typedef struct packed {
    logic        v;
    logic [3:0]  ty;
    logic [31:0] st;
    logic [31:0] len;
    logic [2:0]  err;
    logic        last;
  } res_t;

  res_t res;

  function automatic logic [15:0] col_of(logic [31:0] st, logic [31:0] lso);
    logic [31:0] d;
    d = st - lso;
    return (d >= 32'd65534) ? 16'hffff : 16'(d + 32'd1);
  endfunction

  logic [15:0] line_inc;
  assign line_inc = (line_q == 16'hffff) ? line_q : line_q + 16'd1;

  logic run_is_date;
  assign run_is_date = date_q || (hyph_q >= 2'd2) || (cols_q >= 2'd2);

  // Main sequencer: next state and lexer updates.
  always_comb begin
    logic [7:0]  b;
    logic [31:0] p, k;
    logic [7:0]  q;
    logic        redo, done, isb, fin_now;
    logic [31:0] ilen;
    logic [7:0]  c;
    logic [CntW-1:0] nxt;
    mode_d = mode_q; lit_d = lit_q; line_d = line_q; lso_d = lso_q; pos_d = pos_q;
    tstart_d = tstart_q; hyph_d = hyph_q; cols_d = cols_q; date_d = date_q;
    rtrue_d = rtrue_q; rfalse_d = rfalse_q; err_d = err_q; look_d = look_q;
    seq_d = seq_q; byte_d = byte_q; fin_d = fin_q; idx_d = idx_q; n_d = n_q;
    tokb_d = tokb_q; nph_d = nph_q; frem_d = frem_q;
    ram_we = 1'b0; ram_waddr = '0; ram_wdata = byte_q; ram_raddr = idx_q[RunAw-1:0];
    res = '0;
    b = byte_q; p = pos_q; k = '0; q = 8'h22; redo = 1'b0; done = 1'b0; isb = 1'b0;
    fin_now = 1'b0; ilen = '0; c = ram_rdata; nxt = '0;

    // A byte is taken in at acceptance and lexed in the SEmit state once the output slot is free,
    // where a byte that re-enters idle after a mode ends is redone in place.
    case (seq_q)
      SAccept: begin
        if (acc) begin
          byte_d = byte_req_i;
          fin_d  = final_byte_i;
          frem_d = 1'b0;
          seq_d  = SEmit;
        end
      end
      SEmit: begin
        if (slot_free) begin
          if (err_q) begin
            done = 1'b1;
          end else begin
            q = lit_q ? 8'h27 : 8'h22;
            k = p - tstart_q;
            case (mode_q)
              MIdle: begin
                tstart_d = p;
                done = 1'b1;
                case (b)
                  8'h3d: res = '{1'b1, TokEq, p, 32'd1, ErrNone, 1'b0};
                  8'h5b: res = '{1'b1, TokLBrk, p, 32'd1, ErrNone, 1'b0};
                  8'h5d: res = '{1'b1, TokRBrk, p, 32'd1, ErrNone, 1'b0};
                  8'h7b: res = '{1'b1, TokLBrc, p, 32'd1, ErrNone, 1'b0};
                  8'h7d: res = '{1'b1, TokRBrc, p, 32'd1, ErrNone, 1'b0};
                  8'h2c: res = '{1'b1, TokComma, p, 32'd1, ErrNone, 1'b0};
                  8'h2e: res = '{1'b1, TokDot, p, 32'd1, ErrNone, 1'b0};
                  8'h20, 8'h0d, 8'h09: ;
                  8'h0a: begin line_d = line_inc; lso_d = p + 32'd1; end
                  8'h23: mode_d = MComment;
                  8'h22: begin lit_d = 1'b0; mode_d = MQ1; end
                  8'h27: begin lit_d = 1'b1; mode_d = MQ1; end
                  default: begin
                    if (is_alpha(b) || b == 8'h5f) begin
                      mode_d = MIdent;
                      rtrue_d = (b == 8'h74);
                      rfalse_d = (b == 8'h66);
                    end else if (is_digit(b) || b == 8'h2d || b == 8'h2b) begin
                      mode_d = MNumber;
                      ram_we = 1'b1; ram_waddr = '0;
                      hyph_d = '0; cols_d = '0; date_d = 1'b0;
                      rtrue_d = 1'b0; rfalse_d = 1'b0;
                    end else begin
                      res = '{1'b1, TokUnrec, p, 32'd1, ErrNone, 1'b0};
                    end
                  end
                endcase
              end
              MComment: begin
                if (b == 8'h0a) begin mode_d = MIdle; redo = 1'b1; end
                else done = 1'b1;
              end
              MIdent: begin
                if (is_alpha(b) || is_digit(b) || b == 8'h5f || b == 8'h2d) begin
                  if (!(k < 32'd4 && true_chr(k[2:0]) == b)) rtrue_d = 1'b0;
                  if (!(k < 32'd5 && false_chr(k[2:0]) == b)) rfalse_d = 1'b0;
                  done = 1'b1;
                end else begin
                  isb = (k == 32'd4 && rtrue_q) || (k == 32'd5 && rfalse_q);
                  res = '{1'b1, isb ? TokBool : TokIdent, tstart_q, k, ErrNone, 1'b0};
                  mode_d = MIdle; redo = 1'b1;
                end
              end
              MNumber: begin
                if (is_run(b)) begin
                  done = 1'b1;
                  if (k >= 32'(MaxRun)) begin
                    res = '{1'b1, TokUnrec, tstart_q, k, ErrRunLong, 1'b0};
                    err_d = 1'b1; mode_d = MIdle;
                  end else begin
                    ram_we = 1'b1; ram_waddr = k[RunAw-1:0];
                    if (b == 8'h2d && hyph_q < 2'd2) hyph_d = hyph_q + 2'd1;
                    if (b == 8'h3a && cols_q < 2'd2) cols_d = cols_q + 2'd1;
                    if (b == 8'h54 || b == 8'h5a) date_d = 1'b1;
                  end
                end else begin
                  if (run_is_date) begin
                    res = '{1'b1, TokDate, tstart_q, k, ErrNone, 1'b0};
                    mode_d = MIdle; redo = 1'b1;
                  end else begin
                    n_d = (k > 32'(MaxRun)) ? CntW'(MaxRun) : k[CntW-1:0];
                    idx_d = '0; nph_d = 2'd0; frem_d = 1'b1;
                    mode_d = MIdle;
                    seq_d = SFlushRd;
                  end
                end
              end
              MQ1: begin
                if (b == q) begin mode_d = MQ2; done = 1'b1; end
                else begin mode_d = MBody; redo = 1'b1; end
              end
              MQ2: begin
                if (b == q) begin mode_d = MMl; look_d = '0; done = 1'b1; end
                else begin
                  res = '{1'b1, TokString, tstart_q, k, ErrNone, 1'b0};
                  mode_d = MIdle; redo = 1'b1;
                end
              end
              MBody: begin
                done = 1'b1;
                if (b == q) begin
                  res = '{1'b1, TokString, tstart_q, k + 32'd1, ErrNone, 1'b0};
                  mode_d = MIdle;
                end else if (b == 8'h0a) begin
                  res = '{1'b1, TokUnrec, tstart_q, k, ErrLineBreak, 1'b0};
                  err_d = 1'b1; mode_d = MIdle;
                end else if (!lit_q && b == 8'h5c) begin
                  mode_d = MEsc;
                end
              end
              MEsc: begin mode_d = MBody; done = 1'b1; end
              MMl: begin
                done = 1'b1;
                if (b == q) begin
                  if (look_q >= 2'd2) begin
                    res = '{1'b1, TokString, tstart_q, k + 32'd1, ErrNone, 1'b0};
                    mode_d = MIdle;
                  end else look_d = look_q + 2'd1;
                end else begin
                  look_d = '0;
                  if (b == 8'h0a) line_d = line_inc;
                end
              end
              default: begin mode_d = MIdle; redo = 1'b1; end
            endcase
          end
          // A token closed by a redo is the last one unless the byte, lexed again
          // from idle, gives its own token or the document ends with more tokens.
          if (redo && res.v) res.last = !fin_q && !idle_has_token(b);
          // A redo keeps the byte in SEmit for another lexing pass.
          if (done) begin
            pos_d = err_q ? pos_q : pos_q + 32'd1;
            if (fin_q && !(err_q || err_d)) seq_d = SFinish;
            else if (fin_q) begin seq_d = SAccept; fin_now = 1'b1; end
            else seq_d = SAccept;
            res.last = res.v && !(seq_d == SFinish);
          end
          if (!done && !redo && seq_d != SFlushRd) seq_d = SEmit;
        end
      end
      SFlushRd: begin
        // RAM read of the next run byte is in flight.
        if (slot_free) begin
          if (idx_q >= n_q) seq_d = frem_q ? SEmit : SFinish;
          else seq_d = SFlushScan;
        end
      end
      SFlushScan: begin
        if (slot_free) begin
          nxt = idx_q + CntW'(1);
          ram_raddr = nxt[RunAw-1:0];
          idx_d = nxt;
          seq_d = SFlushRd;
          case (nph_q)
            2'd0: begin
              if (is_digit(c) || c == 8'h2d || c == 8'h2b) begin
                tokb_d = idx_q; nph_d = 2'd1;
              end else begin
                res = '{1'b1, (c == 8'h2e) ? TokDot : TokUnrec,
                        tstart_q + 32'(idx_q), 32'd1, ErrNone, 1'b0};
              end
            end
            2'd1: begin
              if (is_digit(c)) ;
              else if (c == 8'h2e && idx_q + CntW'(1) < n_q) nph_d = 2'd2;
              else begin
                res = '{1'b1, TokInt, tstart_q + 32'(tokb_q), 32'(idx_q - tokb_q),
                        ErrNone, 1'b0};
                nph_d = 2'd0; idx_d = idx_q; ram_raddr = idx_q[RunAw-1:0];
              end
            end
            2'd2: begin
              if (is_digit(c)) nph_d = 2'd3;
              else begin
                // Dot not followed by a digit: integer ends before the dot.
                res = '{1'b1, TokInt, tstart_q + 32'(tokb_q),
                        32'(idx_q - CntW'(1) - tokb_q), ErrNone, 1'b0};
                nph_d = 2'd0; idx_d = idx_q - CntW'(1);
                ram_raddr = idx_d[RunAw-1:0];
              end
            end
            default: begin
              if (!is_digit(c)) begin
                res = '{1'b1, TokFloat, tstart_q + 32'(tokb_q), 32'(idx_q - tokb_q),
                        ErrNone, 1'b0};
                nph_d = 2'd0; idx_d = idx_q; ram_raddr = idx_q[RunAw-1:0];
              end
            end
          endcase
          // Close an open number at the end of the run.
          if (idx_d >= n_q && nph_d != 2'd0 && !res.v) begin
            ilen = 32'(n_q - tokb_d);
            if (nph_d == 2'd2) begin
              res = '{1'b1, TokInt, tstart_q + 32'(tokb_d), ilen - 32'd1, ErrNone, 1'b0};
              idx_d = n_q - CntW'(1); nph_d = 2'd0;
              ram_raddr = idx_d[RunAw-1:0];
            end else begin
              res = '{1'b1, (nph_d == 2'd3) ? TokFloat : TokInt,
                      tstart_q + 32'(tokb_d), ilen, ErrNone, 1'b0};
              nph_d = 2'd0;
            end
          end
        end
      end
      SFinish: begin
        if (slot_free) begin
          fin_now = 1'b1;
          seq_d = SAccept;
          k = pos_q - tstart_q;
          case (mode_q)
            MIdent: begin
              isb = (k == 32'd4 && rtrue_q) || (k == 32'd5 && rfalse_q);
              res = '{1'b1, isb ? TokBool : TokIdent, tstart_q, k, ErrNone, 1'b0};
              mode_d = MIdle; seq_d = SFinish; fin_now = 1'b0;
            end
            MNumber: begin
              mode_d = MIdle;
              if (run_is_date) begin
                res = '{1'b1, TokDate, tstart_q, k, ErrNone, 1'b0};
                seq_d = SFinish; fin_now = 1'b0;
              end else begin
                n_d = (k > 32'(MaxRun)) ? CntW'(MaxRun) : k[CntW-1:0];
                idx_d = '0; nph_d = 2'd0; frem_d = 1'b0;
                seq_d = SFlushRd; fin_now = 1'b0;
              end
            end
            MQ1, MBody, MEsc: begin
              res = '{1'b1, TokUnrec, tstart_q, k, ErrUnterm, 1'b1};
            end
            MQ2: begin
              res = '{1'b1, TokString, tstart_q, k, ErrNone, 1'b0};
              mode_d = MIdle; seq_d = SFinish; fin_now = 1'b0;
            end
            MMl: begin
              res = '{1'b1, TokUnrec, tstart_q, k, ErrUntermMl, 1'b1};
            end
            default: begin
              res = '{1'b1, TokEof, pos_q, 32'd0, ErrNone, 1'b1};
            end
          endcase
        end
      end
      default: seq_d = SAccept;
    endcase

    if (fin_now) begin
      mode_d = MIdle; lit_d = 1'b0; line_d = 16'd1; lso_d = '0; pos_d = '0;
      tstart_d = '0; hyph_d = '0; cols_d = '0; date_d = 1'b0; rtrue_d = 1'b0;
      rfalse_d = 1'b0; err_d = 1'b0; look_d = '0; fin_d = 1'b0;
    end
    // A new error in SEmit marks its result as the last one of this byte.
    if (seq_q == SEmit && res.v && err_d && !err_q) res.last = 1'b1;
    // The final token of a flush is the last one only when the held byte, lexed again
    // from idle, gives no token and the document goes on.
    if (seq_q == SFlushScan && res.v) begin
      res.last = (idx_d >= n_q) && (nph_d == 2'd0) && frem_q && !fin_q &&
                 !idle_has_token(byte_q);
    end
  end

  // Output slot and burst limit.
  always_comb begin
    ov_d = ov_q && !ready_i;
    otype_d = otype_q; ostart_d = ostart_q; olen_d = olen_q; oline_d = oline_q;
    ocol_d = ocol_q; oerr_d = oerr_q; olast_d = olast_q; ocnt_d = ocnt_q;
    if (acc) ocnt_d = '0;
    if (res.v && ocnt_q < 6'(MaxResults)) begin
      ov_d = 1'b1;
      otype_d = res.ty; ostart_d = res.st; olen_d = res.len; oline_d = line_q;
      ocol_d = col_of(res.st, lso_q); oerr_d = res.err;
      olast_d = res.last || (ocnt_q == 6'(MaxResults - 1));
      ocnt_d = ocnt_q + 6'd1;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the TOML byte tokenizer: random documents against a token predictor.
`timescale 1ns / 1ps
module testbench
  import tbt_pkg::*;
;

  typedef struct {
    logic [3:0]  ty;
    logic [31:0] st;
    logic [31:0] ln;
    logic [15:0] li;
    logic [15:0] co;
    logic [2:0]  er;
    logic        la;
  } token_t;

  typedef struct {
    logic [7:0] b;
    logic       f;
  } src_byte_t;

  logic        clk_i, rst_ni;
  logic        valid_i, ready_o, final_byte_i;
  logic [7:0]  byte_req_i;
  logic        valid_o, ready_i;
  logic [3:0]  token_type_o;
  logic [31:0] start_offset_o, token_length_o;
  logic [15:0] line_number_o, column_o;
  logic [2:0]  error_code_o;
  logic        last_result_o;

  toml_byte_tokenizer_unit i_dut (
    .clk_i, .rst_ni, .valid_i, .ready_o, .byte_req_i, .final_byte_i,
    .valid_o, .ready_i, .token_type_o, .start_offset_o, .token_length_o,
    .line_number_o, .column_o, .error_code_o, .last_result_o
  );

  // Lexer state of the predictor.
  logic [7:0]  run_bytes [MaxRun];
  mode_e       lex_mode;
  logic        is_literal;
  logic [31:0] line_cnt, line_base, byte_pos, tok_start;
  logic [1:0]  n_hyph, n_colon;
  logic        has_date, may_true, may_false, doc_failed;
  int          n_quotes, burst_n;

  token_t      token_q[$];
  src_byte_t   source_q[$];
  int          n_errors = 0, n_bytes = 0, n_tokens = 0, n_docs = 0;
  int          quiet_cycles;

  function automatic void clear_lexer();
    lex_mode = MIdle;
    is_literal = 1'b0;
    line_cnt = 1;
    line_base = 0;
    byte_pos = 0;
    tok_start = 0;
    {n_hyph, n_colon, has_date, may_true, may_false} = '0;
    doc_failed = 1'b0;
    n_quotes = 0;
  endfunction

  function automatic void push_token(tok_e ty, logic [31:0] start, logic [31:0] len,
                                     err_e err);
    token_t t;
    logic [31:0] d;
    if (burst_n >= MaxResults) return;
    d = start - line_base;
    t.ty = ty;
    t.st = start;
    t.ln = len;
    t.li = line_cnt[15:0];
    t.co = (d >= 32'd65534) ? 16'hffff : 16'(d + 1);
    t.er = err;
    t.la = 1'b0;
    token_q = {token_q, t};
    burst_n++;
  endfunction

  function automatic void fail_token(logic [31:0] len, err_e err);
    push_token(TokUnrec, tok_start, len, err);
    doc_failed = 1'b1;
    lex_mode = MIdle;
  endfunction

  function automatic void end_word(logic [31:0] stop);
    logic [31:0] len;
    len = stop - tok_start;
    push_token(((len == 4 && may_true) || (len == 5 && may_false)) ? TokBool : TokIdent,
               tok_start, len, ErrNone);
  endfunction

  // Splits a finished number run into date, integer, float, dot and unrecognized tokens.
  function automatic void end_number(logic [31:0] stop);
    int n, i, j;
    tok_e ty;
    n = int'(stop - tok_start);
    if (n > MaxRun) n = MaxRun;
    if (has_date || n_hyph >= 2 || n_colon >= 2) begin
      push_token(TokDate, tok_start, stop - tok_start, ErrNone);
      return;
    end
    i = 0;
    while (i < n) begin
      if (is_digit(run_bytes[i]) || run_bytes[i] == "-" || run_bytes[i] == "+") begin
        j = i + 1;
        ty = TokInt;
        while (j < n && is_digit(run_bytes[j])) j++;
        if (j + 1 < n && run_bytes[j] == "." && is_digit(run_bytes[j+1])) begin
          j += 2;
          while (j < n && is_digit(run_bytes[j])) j++;
          ty = TokFloat;
        end
        push_token(ty, tok_start + i, j - i, ErrNone);
        i = j;
      end else begin
        push_token(run_bytes[i] == "." ? TokDot : TokUnrec, tok_start + i, 1, ErrNone);
        i++;
      end
    end
  endfunction

  function automatic void lex_byte(logic [7:0] b);
    logic [31:0] p, k;
    logic [7:0] q;
    p = byte_pos;
    forever begin
      q = is_literal ? 8'h27 : 8'h22;
      case (lex_mode)
        MIdle: begin
          tok_start = p;
          case (b)
            "=": begin push_token(TokEq, p, 1, ErrNone); return; end
            "[": begin push_token(TokLBrk, p, 1, ErrNone); return; end
            "]": begin push_token(TokRBrk, p, 1, ErrNone); return; end
            "{": begin push_token(TokLBrc, p, 1, ErrNone); return; end
            "}": begin push_token(TokRBrc, p, 1, ErrNone); return; end
            ",": begin push_token(TokComma, p, 1, ErrNone); return; end
            ".": begin push_token(TokDot, p, 1, ErrNone); return; end
            8'h20, 8'h0d, 8'h09: return;
            8'h0a: begin
              if (line_cnt < 65535) line_cnt++;
              line_base = p + 1;
              return;
            end
            "#": begin lex_mode = MComment; return; end
            8'h22: begin is_literal = 1'b0; lex_mode = MQ1; return; end
            8'h27: begin is_literal = 1'b1; lex_mode = MQ1; return; end
            default: ;
          endcase
          if (is_alpha(b) || b == "_") begin
            lex_mode = MIdent;
            may_true = (b == "t");
            may_false = (b == "f");
          end else if (is_digit(b) || b == "-" || b == "+") begin
            lex_mode = MNumber;
            run_bytes[0] = b;
            {n_hyph, n_colon, has_date, may_true, may_false} = '0;
          end else begin
            push_token(TokUnrec, p, 1, ErrNone);
          end
          return;
        end
        MComment: begin
          if (b != 8'h0a) return;
          lex_mode = MIdle;
        end
        MIdent: begin
          if (is_alpha(b) || is_digit(b) || b == "_" || b == "-") begin
            k = p - tok_start;
            if (!(k < 4 && true_chr(k[2:0]) == b)) may_true = 1'b0;
            if (!(k < 5 && false_chr(k[2:0]) == b)) may_false = 1'b0;
            return;
          end
          end_word(p);
          lex_mode = MIdle;
        end
        MNumber: begin
          if (is_run(b)) begin
            k = p - tok_start;
            if (k >= MaxRun) begin fail_token(k, ErrRunLong); return; end
            run_bytes[k] = b;
            if (b == "-" && n_hyph < 2) n_hyph++;
            if (b == ":" && n_colon < 2) n_colon++;
            if (b == "T" || b == "Z") has_date = 1'b1;
            return;
          end
          end_number(p);
          lex_mode = MIdle;
        end
        MQ1: begin
          if (b == q) begin lex_mode = MQ2; return; end
          lex_mode = MBody;
        end
        MQ2: begin
          if (b == q) begin lex_mode = MMl; n_quotes = 0; return; end
          push_token(TokString, tok_start, p - tok_start, ErrNone);
          lex_mode = MIdle;
        end
        MBody: begin
          if (b == q) begin
            push_token(TokString, tok_start, p + 1 - tok_start, ErrNone);
            lex_mode = MIdle;
          end else if (b == 8'h0a) begin
            fail_token(p - tok_start, ErrLineBreak);
          end else if (!is_literal && b == 8'h5c) begin
            lex_mode = MEsc;
          end
          return;
        end
        MEsc: begin lex_mode = MBody; return; end
        MMl: begin
          if (b == q) begin
            if (n_quotes >= 2) begin
              push_token(TokString, tok_start, p + 1 - tok_start, ErrNone);
              lex_mode = MIdle;
            end else begin
              n_quotes++;
            end
            return;
          end
          n_quotes = 0;
          if (b == 8'h0a && line_cnt < 65535) line_cnt++;
          return;
        end
        default: lex_mode = MIdle;
      endcase
    end
  endfunction

  // Works out every token that one accepted request produces.
  function automatic void predict_tokens(logic [7:0] b, logic fin);
    burst_n = 0;
    if (!doc_failed) begin
      lex_byte(b);
      byte_pos++;
      if (fin && !doc_failed) begin
        case (lex_mode)
          MIdent: end_word(byte_pos);
          MNumber: end_number(byte_pos);
          MQ1, MBody, MEsc: fail_token(byte_pos - tok_start, ErrUnterm);
          MQ2: push_token(TokString, tok_start, byte_pos - tok_start, ErrNone);
          MMl: fail_token(byte_pos - tok_start, ErrUntermMl);
          default: ;
        endcase
        if (!doc_failed) push_token(TokEof, byte_pos, 0, ErrNone);
      end
    end
    if (fin) clear_lexer();
    if (burst_n > 0) token_q[token_q.size()-1].la = 1'b1;
  endfunction

  task automatic add_text(string s, bit fin);
    for (int i = 0; i < s.len(); i++)
      source_q = {source_q, src_byte_t'{s[i], fin && (i == s.len() - 1)}};
  endtask

  function automatic string pick_one(string a, string b);
    return $urandom_range(0, 1) ? a : b;
  endfunction

  function automatic string pick_fragment();
    string s, cs;
    int n;
    case ($urandom_range(0, 19))
      0: return "key";
      1: return "true";
      2: return "false";
      3: return pick_one("tru", "falsey_x-9");
      4: return " = ";
      5: return "[a.b]\n";
      6: return "{x=1,y=2}";
      7: return "\n\t\r ";
      8: return "# note\n";
      9: return "\"ab\\\"c\\\n\"";
      10: return "'x\\'";
      11: return pick_one("\"\"\"l1\n\"\"l2\"\"\"", "'''a\n'''");
      12: return pick_one("''", "\"\" ");
      13: return pick_one("1979-05-27T07:32:00Z", "12:30:00");
      14: return pick_one("3.14", "+7.5.");
      15: begin
        cs = "0123456789-:.TZ+";
        s = "";
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          s = {s, " "};
          s[i] = (i == 0) ? cs[$urandom_range(0, 9)] : cs[$urandom_range(0, 15)];
        end
        return s;
      end
      16: return "\"a\nb\"";
      17: return pick_one("\"open", "'''open");
      default: begin
        s = " ";
        s[0] = 8'($urandom_range(1, 255));
        return s;
      end
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Request side.
  int src_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    src_byte_t nxt;
    logic v;
    if (!rst_ni) begin
      valid_i <= 1'b0;
      byte_req_i <= '0;
      final_byte_i <= 1'b0;
      src_gap = 0;
    end else begin
      v = valid_i;
      if (valid_i && ready_o) begin
        predict_tokens(byte_req_i, final_byte_i);
        n_bytes++;
        if (final_byte_i) n_docs++;
        v = 1'b0;
      end
      if (!v) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (source_q.size() > 0) begin
          nxt = source_q.pop_front();
          byte_req_i <= nxt.b;
          final_byte_i <= nxt.f;
          v = 1'b1;
          src_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
        end
      end
      valid_i <= v;
    end
  end

  // Result side.
  int snk_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    token_t e;
    if (!rst_ni) begin
      ready_i <= 1'b0;
      snk_gap = 0;
      quiet_cycles = 0;
    end else begin
      quiet_cycles = (valid_i && ready_o) ? 0 : quiet_cycles + 1;
      if (valid_o && ready_i) begin
        quiet_cycles = 0;
        n_tokens++;
        if (token_q.size() == 0) begin
          $error("token with no request behind it: type %0d", token_type_o);
          n_errors++;
        end else begin
          e = token_q.pop_front();
          if (token_type_o !== e.ty) begin
            $error("token_type expected %0d actual %0d", e.ty, token_type_o); n_errors++;
          end
          if (start_offset_o !== e.st) begin
            $error("start_offset expected %0d actual %0d", e.st, start_offset_o); n_errors++;
          end
          if (token_length_o !== e.ln) begin
            $error("token_length expected %0d actual %0d", e.ln, token_length_o); n_errors++;
          end
          if (line_number_o !== e.li) begin
            $error("line_number expected %0d actual %0d", e.li, line_number_o); n_errors++;
          end
          if (column_o !== e.co) begin
            $error("column expected %0d actual %0d", e.co, column_o); n_errors++;
          end
          if (error_code_o !== e.er) begin
            $error("error_code expected %0d actual %0d", e.er, error_code_o); n_errors++;
          end
          if (last_result_o !== e.la) begin
            $error("last_result expected %0d actual %0d", e.la, last_result_o); n_errors++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        ready_i <= 1'b0;
      end else begin
        ready_i <= 1'b1;
        if (valid_o && ready_i)
          snk_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
      end
      if (quiet_cycles >= 5000) begin
        $display("toml_byte_tokenizer_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    string doc;
    int n;
    clear_lexer();
    rst_ni = 1'b0;

    // Directed documents: every token kind, escapes, high bytes and each error.
    add_text("a=true\n[t]{f=false,x=1.5}# c\ns=\"q\\\"\"\nm='''1\n2'''d=1-2T3", 0);
    source_q = {source_q, src_byte_t'{8'hff, 1'b0}};
    source_q = {source_q, src_byte_t'{8'h80, 1'b0}};
    add_text(" ''.", 1);
    add_text("\"ab\ncd", 1);
    add_text("12345678901234567890123456789012345", 1);
    add_text("\"open", 1);
    add_text("'''x", 1);
    add_text("7", 1);

    while (source_q.size() < 300) begin
      doc = "";
      n = $urandom_range(2, 10);
      for (int i = 0; i < n; i++) doc = {doc, pick_fragment()};
      add_text(doc, 1);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (source_q.size() == 0 && !valid_i);
    wait (token_q.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("Lexed %0d bytes in %0d documents; checked %0d tokens.", n_bytes, n_docs,
             n_tokens);
    if (n_errors == 0 && token_q.size() == 0)
      $display("toml_byte_tokenizer_unit regression: pass");
    else
      $display("toml_byte_tokenizer_unit regression: fail");
    $finish;
  end

endmodule
